### sv/ascii_command_frame_parser_unit_defines.svh
// Assertion macros for the ASCII command frame parser unit.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef ASCII_COMMAND_FRAME_PARSER_UNIT_DEFINES_SVH
`define ASCII_COMMAND_FRAME_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled while in reset.
`define ACFP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame parser assertion failed");

// Next-cycle implication, sampled on clk, disabled while in reset.
`define ACFP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame parser assertion failed");

`endif

### sv/acfp_pkg.sv
// Shared types, constants and tables for the ASCII command frame parser.
// Depends on nothing; used by every module of the block but the queue.
package acfp_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_CHARS_DEFAULT = 16;
    localparam int FRAC_BITS_DEFAULT = 16;

    // Depth of the queue between the parser and the converter.
    localparam int QUEUE_DEPTH = 2;

    // Fraction handling: the first five fraction digits are kept.
    localparam int KEEP_DIGITS = 5;
    localparam int FRAC_ACC_W  = 17;
    localparam int FRAC_DIG_W  = 3;

    // The fraction denominator 100000 is 3125 * 2^5. With the power of two
    // taken out, half the denominator becomes 1562 (the dropped half is
    // below one unit). The odd part is divided by a reciprocal multiply
    // that is exact for dividends below 2^RECIP_IN_W.
    localparam int FRAC_DEN_SHIFT = 5;
    localparam int FRAC_DEN_ODD   = 3125;
    localparam int FRAC_HALF_ODD  = 1562;
    localparam int RECIP_IN_W     = 29;
    localparam int RECIP_MULT_W   = 30;
    localparam int RECIP_SHIFT    = 41;
    localparam logic [RECIP_MULT_W-1:0] RECIP_MULT = 30'd703687442;

    // Configuration port.
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_START_IDX = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_IDX  = 8'd1;
    localparam logic [7:0] START_RESET = 8'h24;
    localparam logic [7:0] STOP_RESET  = 8'h23;

    // Character codes of the decimal field.
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_ID    = 2'd1,
        PH_FIELD = 2'd2
    } parse_phase_t;

    // Fixed-width part of one completed frame.
    typedef struct packed {
        logic [7:0]            command_id;
        logic                  negative;
        logic                  overflowed;
        logic [FRAC_DIG_W-1:0] frac_digits;
        logic [FRAC_ACC_W-1:0] frac_acc;
    } frame_hdr_t;

    typedef struct packed {
        parse_phase_t phase;
        logic         frame_push;
    } front_status_t;

    // Scale that brings the kept fraction digits up to five digits.
    function automatic logic [FRAC_ACC_W-1:0] frac_scale(input logic [FRAC_DIG_W-1:0] digits);
        logic [FRAC_ACC_W-1:0] scale;
        case (digits)
            3'd0:    scale = 17'd100000;
            3'd1:    scale = 17'd10000;
            3'd2:    scale = 17'd1000;
            3'd3:    scale = 17'd100;
            3'd4:    scale = 17'd10;
            default: scale = 17'd1;
        endcase
        return scale;
    endfunction

endpackage

### sv/acfp_front.sv
// Byte parser: frame phases, field checks and the digit accumulators.
// Depends on acfp_pkg; pushes completed frames into acfp_queue.
module acfp_front #(
    parameter int MAX_CHARS = acfp_pkg::MAX_CHARS_DEFAULT,
    parameter int FRAC_BITS = acfp_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [7:0]               rx_byte,
    input  logic [7:0]               start_byte,
    input  logic [7:0]               stop_byte,
    input  logic                     q_full,
    output acfp_pkg::frame_hdr_t     frame_hdr,
    output logic [31-FRAC_BITS:0]    frame_int,
    output acfp_pkg::front_status_t  status
);

    localparam int IW = 32 - FRAC_BITS;
    localparam int CW = $clog2(MAX_CHARS + 1);
    localparam logic [IW-1:0] INT_CAP = {1'b1, {(IW-1){1'b0}}};

    acfp_pkg::parse_phase_t phase_reg, phase_next;
    logic                            sign_seen_reg, sign_seen_next;
    logic                            point_seen_reg, point_seen_next;
    logic                            negative_reg, negative_next;
    logic [CW-1:0]                   char_count_reg, char_count_next;
    logic [7:0]                      frame_id_reg, frame_id_next;
    logic [IW-1:0]                   int_acc_reg, int_acc_next;
    logic [acfp_pkg::FRAC_ACC_W-1:0] frac_acc_reg, frac_acc_next;
    logic [acfp_pkg::FRAC_DIG_W-1:0] frac_digits_reg, frac_digits_next;
    logic                            overflowed_reg, overflowed_next;

    logic          accept;
    logic          push;
    logic          is_sign;
    logic          is_point;
    logic          is_digit;
    logic          room;
    logic [3:0]    digit;
    logic [IW+3:0] int_prod;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign is_sign  = (rx_byte == acfp_pkg::CH_PLUS) || (rx_byte == acfp_pkg::CH_MINUS);
    assign is_point = (rx_byte == acfp_pkg::CH_POINT);
    assign is_digit = rx_byte inside {[acfp_pkg::CH_ZERO:acfp_pkg::CH_NINE]};
    assign digit    = rx_byte[3:0];
    assign room     = char_count_reg < CW'(MAX_CHARS);
    assign int_prod = (IW+4)'(int_acc_reg) * (IW+4)'(10) + (IW+4)'(digit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= acfp_pkg::PH_IDLE;
            sign_seen_reg   <= 1'b0;
            point_seen_reg  <= 1'b0;
            negative_reg    <= 1'b0;
            char_count_reg  <= '0;
            frame_id_reg    <= '0;
            int_acc_reg     <= '0;
            frac_acc_reg    <= '0;
            frac_digits_reg <= '0;
            overflowed_reg  <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            sign_seen_reg   <= sign_seen_next;
            point_seen_reg  <= point_seen_next;
            negative_reg    <= negative_next;
            char_count_reg  <= char_count_next;
            frame_id_reg    <= frame_id_next;
            int_acc_reg     <= int_acc_next;
            frac_acc_reg    <= frac_acc_next;
            frac_digits_reg <= frac_digits_next;
            overflowed_reg  <= overflowed_next;
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        sign_seen_next   = sign_seen_reg;
        point_seen_next  = point_seen_reg;
        negative_next    = negative_reg;
        char_count_next  = char_count_reg;
        frame_id_next    = frame_id_reg;
        int_acc_next     = int_acc_reg;
        frac_acc_next    = frac_acc_reg;
        frac_digits_next = frac_digits_reg;
        overflowed_next  = overflowed_reg;
        push             = 1'b0;

        if (accept)
        begin
            case (phase_reg)
                acfp_pkg::PH_IDLE, acfp_pkg::PH_ID:
                begin
                    sign_seen_next   = 1'b0;
                    point_seen_next  = 1'b0;
                    negative_next    = 1'b0;
                    char_count_next  = '0;
                    int_acc_next     = '0;
                    frac_acc_next    = '0;
                    frac_digits_next = '0;
                    overflowed_next  = 1'b0;
                    if (phase_reg == acfp_pkg::PH_IDLE)
                    begin
                        if (rx_byte == start_byte)
                        begin
                            phase_next = acfp_pkg::PH_ID;
                        end
                    end
                    else if (rx_byte != start_byte)
                    begin
                        frame_id_next = rx_byte;
                        phase_next    = acfp_pkg::PH_FIELD;
                    end
                end
                acfp_pkg::PH_FIELD:
                begin
                    if (is_sign)
                    begin
                        // A sign is legal only as the very first character.
                        if (sign_seen_reg || (char_count_reg != '0) || !room)
                        begin
                            phase_next = acfp_pkg::PH_IDLE;
                        end
                        else
                        begin
                            sign_seen_next  = 1'b1;
                            negative_next   = (rx_byte == acfp_pkg::CH_MINUS);
                            char_count_next = char_count_reg + CW'(1);
                        end
                    end
                    else if (is_point)
                    begin
                        if (point_seen_reg || !room)
                        begin
                            phase_next = acfp_pkg::PH_IDLE;
                        end
                        else
                        begin
                            point_seen_next = 1'b1;
                            char_count_next = char_count_reg + CW'(1);
                        end
                    end
                    else if (is_digit)
                    begin
                        if (!room)
                        begin
                            phase_next = acfp_pkg::PH_IDLE;
                        end
                        else
                        begin
                            char_count_next = char_count_reg + CW'(1);
                            if (point_seen_reg)
                            begin
                                // Fraction digits past the fifth are dropped.
                                if (frac_digits_reg < acfp_pkg::FRAC_DIG_W'(acfp_pkg::KEEP_DIGITS))
                                begin
                                    frac_acc_next = frac_acc_reg * acfp_pkg::FRAC_ACC_W'(10)
                                                  + acfp_pkg::FRAC_ACC_W'(digit);
                                    frac_digits_next = frac_digits_reg
                                                     + acfp_pkg::FRAC_DIG_W'(1);
                                end
                            end
                            else if (int_prod > (IW+4)'(INT_CAP))
                            begin
                                int_acc_next    = INT_CAP;
                                overflowed_next = 1'b1;
                            end
                            else
                            begin
                                int_acc_next = int_prod[IW-1:0];
                            end
                        end
                    end
                    else if (rx_byte == start_byte)
                    begin
                        sign_seen_next   = 1'b0;
                        point_seen_next  = 1'b0;
                        negative_next    = 1'b0;
                        char_count_next  = '0;
                        int_acc_next     = '0;
                        frac_acc_next    = '0;
                        frac_digits_next = '0;
                        overflowed_next  = 1'b0;
                        phase_next       = acfp_pkg::PH_ID;
                    end
                    else if (rx_byte == stop_byte)
                    begin
                        push       = 1'b1;
                        phase_next = acfp_pkg::PH_IDLE;
                    end
                    else
                    begin
                        phase_next = acfp_pkg::PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = acfp_pkg::PH_IDLE;
                end
            endcase
        end
    end

    assign frame_hdr.command_id  = frame_id_reg;
    assign frame_hdr.negative    = negative_reg;
    assign frame_hdr.overflowed  = overflowed_reg;
    assign frame_hdr.frac_digits = frac_digits_reg;
    assign frame_hdr.frac_acc    = frac_acc_reg;
    assign frame_int             = int_acc_reg;
    assign status.phase          = phase_reg;
    assign status.frame_push     = push;

endmodule

### sv/acfp_queue.sv
// Short first-in first-out queue of completed frames.
// Depends on nothing but its parameters; sits between parser and converter.
module acfp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == NW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + NW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### sv/acfp_back.sv
// Converter pipeline: fraction scaling, division by the constant fraction
// denominator through a reciprocal multiply, saturation and the output register.
// Depends on acfp_pkg.
module acfp_back #(
    parameter int FRAC_BITS = acfp_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  acfp_pkg::frame_hdr_t  frame_hdr,
    input  logic [31-FRAC_BITS:0] frame_int,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            command_id,
    output logic signed [31:0]    value_q15_16,
    output logic                  saturated
);

    localparam int IW = 32 - FRAC_BITS;
    localparam int RW = acfp_pkg::FRAC_ACC_W;
    localparam int QW = FRAC_BITS + 1;
    localparam int WW = acfp_pkg::RECIP_IN_W;
    localparam int MW = acfp_pkg::RECIP_MULT_W;
    localparam int PW = WW + MW;
    localparam int SH = acfp_pkg::RECIP_SHIFT;

    // The rounded fraction is (fa5 * 2^F + 50000) / 100000. Taking the factor
    // 2^5 out of both leaves (fa5 * 2^(F-5) + 1562) / 3125. With
    // 2^(F-5) = 3125 * QC + RC this is fa5 * QC plus (fa5 * RC + 1562) / 3125,
    // and that last dividend stays below 2^29, where the reciprocal is exact.
    localparam longint unsigned FRAC_POW = 64'd1 << (FRAC_BITS - acfp_pkg::FRAC_DEN_SHIFT);
    localparam int QC = int'(FRAC_POW / 64'(acfp_pkg::FRAC_DEN_ODD));
    localparam int RC = int'(FRAC_POW % 64'(acfp_pkg::FRAC_DEN_ODD));

    logic adv;

    // Scaling stage.
    logic                 a_vld_reg;
    logic [RW-1:0]        a_fa5_reg;
    logic [7:0]           a_id_reg;
    logic                 a_neg_reg;
    logic                 a_ovf_reg;
    logic [IW-1:0]        a_int_reg;
    logic [2*RW-1:0]      a_prod;

    // Split stage.
    logic                 b_vld_reg;
    logic [WW-1:0]        b_w_reg;
    logic [QW-1:0]        b_p_reg;
    logic [7:0]           b_id_reg;
    logic                 b_neg_reg;
    logic                 b_ovf_reg;
    logic [IW-1:0]        b_int_reg;
    logic [WW-1:0]        b_w;
    logic [QW-1:0]        b_p;

    // Quotient stage.
    logic                 c_vld_reg;
    logic [QW-1:0]        c_q_reg;
    logic [7:0]           c_id_reg;
    logic                 c_neg_reg;
    logic                 c_ovf_reg;
    logic [IW-1:0]        c_int_reg;
    logic [PW-1:0]        c_prod;
    logic [QW-1:0]        c_q;

    // Output stage.
    logic                 out_valid_reg;
    logic [7:0]           out_id_reg;
    logic [31:0]          out_value_reg;
    logic                 out_sat_reg;
    logic [32:0]          mag;
    logic [32:0]          lim;
    logic [32:0]          mag_clamped;
    logic [31:0]          final_value;
    logic                 final_sat;

    // The whole pipeline moves together whenever the output can take a beat.
    assign adv   = !out_valid_reg || out_ready;
    assign q_pop = adv && q_valid;

    assign a_prod = RW'(frame_hdr.frac_acc) * acfp_pkg::frac_scale(frame_hdr.frac_digits);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_fa5_reg <= a_prod[RW-1:0];
            a_id_reg  <= frame_hdr.command_id;
            a_neg_reg <= frame_hdr.negative;
            a_ovf_reg <= frame_hdr.overflowed;
            a_int_reg <= frame_int;
        end
    end

    assign b_w = WW'(a_fa5_reg) * WW'(RC) + WW'(acfp_pkg::FRAC_HALF_ODD);
    assign b_p = QW'((RW+8)'(a_fa5_reg) * (RW+8)'(QC));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_w_reg   <= b_w;
            b_p_reg   <= b_p;
            b_id_reg  <= a_id_reg;
            b_neg_reg <= a_neg_reg;
            b_ovf_reg <= a_ovf_reg;
            b_int_reg <= a_int_reg;
        end
    end

    // Multiply by ceil(2^41 / 3125) and keep the bits above the shift.
    assign c_prod = PW'(b_w_reg) * PW'(acfp_pkg::RECIP_MULT);
    assign c_q    = b_p_reg + QW'(c_prod[PW-1:SH]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_q_reg   <= c_q;
            c_id_reg  <= b_id_reg;
            c_neg_reg <= b_neg_reg;
            c_ovf_reg <= b_ovf_reg;
            c_int_reg <= b_int_reg;
        end
    end

    // Join integer and fraction, clamp to the signed range, apply the sign.
    always_comb
    begin
        mag         = {1'b0, c_int_reg, {FRAC_BITS{1'b0}}} + 33'(c_q_reg);
        lim         = c_neg_reg ? 33'h080000000 : 33'h07FFFFFFF;
        final_sat   = c_ovf_reg || (mag > lim);
        mag_clamped = final_sat ? lim : mag;
        final_value = c_neg_reg ? (32'd0 - mag_clamped[31:0]) : mag_clamped[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_id_reg    <= c_id_reg;
            out_value_reg <= final_value;
            out_sat_reg   <= final_sat;
        end
    end

    assign out_valid    = out_valid_reg;
    assign command_id   = out_id_reg;
    assign value_q15_16 = out_value_reg;
    assign saturated    = out_sat_reg;

endmodule

### sv/ascii_command_frame_parser_unit.sv
// Top level of the ASCII command frame parser: configuration registers,
// parser, frame queue and converter. Depends on acfp_pkg and the defines header.
//
// Channel   Direction  Handshake            Beat contents
// in        input      in_valid/in_ready    rx_byte
// out       output     out_valid/out_ready  command_id, value_q15_16, saturated
// cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One input byte is taken per cycle; in_ready drops only while the two-entry
// frame queue is full. The edge that takes a stop byte writes the queue; the
// frame then passes through the scaling, split, quotient and output registers
// in that order, and out_valid rises once the output register holds it.
// The converter delivers one result per cycle while out_ready is high.
// Reset clears the phase, the queue and all pipeline valid bits and loads
// start_byte with 0x24 and stop_byte with 0x23. A stalled output freezes the
// converter pipeline in place; the parser keeps running until the queue fills.
module ascii_command_frame_parser_unit #(
    parameter int MAX_CHARS = acfp_pkg::MAX_CHARS_DEFAULT,
    parameter int FRAC_BITS = acfp_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     rx_byte,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     command_id,
    output logic signed [31:0]             value_q15_16,
    output logic                           saturated,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [acfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data
);

    `include "ascii_command_frame_parser_unit_defines.svh"

    localparam int IW   = 32 - FRAC_BITS;
    localparam int QD_W = $bits(acfp_pkg::frame_hdr_t) + IW;

    // Start and stop bytes. The user must write only while the block is idle;
    // this is not enforced, the port is always ready. Other indexes are ignored.
    logic [7:0] start_byte_reg, start_byte_next;
    logic [7:0] stop_byte_reg, stop_byte_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        start_byte_next = start_byte_reg;
        stop_byte_next  = stop_byte_reg;
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == acfp_pkg::CFG_START_IDX)
            begin
                start_byte_next = cfg_data;
            end
            else if (cfg_index == acfp_pkg::CFG_STOP_IDX)
            begin
                stop_byte_next = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= acfp_pkg::START_RESET;
            stop_byte_reg  <= acfp_pkg::STOP_RESET;
        end
        else
        begin
            start_byte_reg <= start_byte_next;
            stop_byte_reg  <= stop_byte_next;
        end
    end

    acfp_pkg::frame_hdr_t    front_hdr;
    logic [IW-1:0]           front_int;
    acfp_pkg::front_status_t front_status;
    logic                    q_full;
    logic                    q_not_empty;
    logic                    q_pop;
    logic [QD_W-1:0]         q_push_data;
    logic [QD_W-1:0]         q_pop_data;
    acfp_pkg::frame_hdr_t    back_hdr;
    logic [IW-1:0]           back_int;

    // The parser works byte by byte and hands each finished frame on as one
    // record: id, sign, overflow flag, kept fraction digits and the integer.
    acfp_front #(
        .MAX_CHARS (MAX_CHARS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .start_byte (start_byte_reg),
        .stop_byte  (stop_byte_reg),
        .q_full     (q_full),
        .frame_hdr  (front_hdr),
        .frame_int  (front_int),
        .status     (front_status)
    );

    assign q_push_data = {front_hdr, front_int};

    acfp_queue #(
        .WIDTH (QD_W),
        .DEPTH (acfp_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_status.frame_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .not_empty (q_not_empty)
    );

    assign back_hdr = acfp_pkg::frame_hdr_t'(q_pop_data[QD_W-1:IW]);
    assign back_int = q_pop_data[IW-1:0];

    // The converter turns a record into the signed fixed-point result.
    acfp_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_not_empty),
        .q_pop        (q_pop),
        .frame_hdr    (back_hdr),
        .frame_int    (back_int),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .command_id   (command_id),
        .value_q15_16 (value_q15_16),
        .saturated    (saturated)
    );

    // A clamped result is always one of the two extreme codes.
    `ACFP_ASSERT_IMPL(a_sat_extreme, out_valid && saturated,
        value_q15_16 == 32'sh7FFFFFFF || value_q15_16 == 32'sh80000000)
    // A start byte seen while idle always opens a frame.
    `ACFP_ASSERT_NEXT(a_start_opens,
        in_valid && in_ready && front_status.phase == acfp_pkg::PH_IDLE
            && rx_byte == start_byte_reg,
        front_status.phase == acfp_pkg::PH_ID)
    // A finished frame never meets a full queue.
    `ACFP_ASSERT_IMPL(a_push_room, front_status.frame_push, !q_full)

endmodule

### tb/tb_top.sv
// Self-checking testbench for the ASCII command frame parser unit.
// Depends on acfp_pkg and the ascii_command_frame_parser_unit RTL.
// Mirrors the parser in a small class and compares every output beat.
`timescale 1ns / 1ps

module tb_top;
    import acfp_pkg::*;

    // Cycles that the converter pipeline may still need after the last
    // expected frame has come out (four stages at most, with margin).
    localparam int DRAIN_SLACK  = 24;
    // Length of the long output hold-off used to fill the frame queue.
    localparam int HOLD_CYCLES  = 300;
    // Beats of random frames, some malformed, sent in each idling phase.
    localparam int PHASE_BEATS  = 32;
    // Short frames streamed in while the output is held off.
    localparam int HOLD_FRAMES  = 10;

    typedef struct {
        logic [7:0]  command_id;
        logic [31:0] value;
        logic        saturated;
    } frame_result_t;

    // The class keeps its own copy of the parser state and the two
    // registers, predicts the result of every accepted input beat and
    // checks each output beat against the oldest frame still awaited.
    class frame_checker;
        localparam int MAX_CHARS = MAX_CHARS_DEFAULT;
        localparam int FRAC_BITS = FRAC_BITS_DEFAULT;

        logic [7:0]        start_code;
        logic [7:0]        stop_code;
        parse_phase_t      phase;
        bit                sign_seen;
        bit                point_seen;
        bit                negative;
        int                char_count;
        logic [7:0]        frame_id;
        longint unsigned   int_mag;
        longint unsigned   frac_mag;
        int                frac_digits;
        bit                overflowed;
        frame_result_t     awaited_frames[$];
        int                errors;

        function new();
            start_code = START_RESET;
            stop_code  = STOP_RESET;
            phase      = PH_IDLE;
            frame_id   = 8'h00;
            errors     = 0;
            clear_field();
        endfunction

        function void clear_field();
            sign_seen   = 1'b0;
            point_seen  = 1'b0;
            negative    = 1'b0;
            char_count  = 0;
            int_mag     = 0;
            frac_mag    = 0;
            frac_digits = 0;
            overflowed  = 1'b0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
            if (idx == CFG_START_IDX)
            begin
                start_code = data;
            end
            else if (idx == CFG_STOP_IDX)
            begin
                stop_code = data;
            end
        endfunction

        function frame_result_t finish_frame();
            frame_result_t   r;
            longint unsigned p;
            longint unsigned frac;
            longint unsigned mag;
            longint unsigned lim;
            logic [31:0]     v;
            p = 1;
            for (int i = 0; i < frac_digits; i++)
            begin
                p = p * 10;
            end
            frac = ((frac_mag << FRAC_BITS) + p / 2) / p;
            mag  = (int_mag << FRAC_BITS) + frac;
            lim  = negative ? 64'h8000_0000 : 64'h7FFF_FFFF;
            r.saturated = 1'b0;
            if (overflowed || mag > lim)
            begin
                mag = lim;
                r.saturated = 1'b1;
            end
            v = mag[31:0];
            if (negative)
            begin
                v = -v;
            end
            r.command_id = frame_id;
            r.value      = v;
            return r;
        endfunction

        // Advance the parser copy by one accepted byte.
        function void take_byte(logic [7:0] b);
            longint unsigned cap;
            longint unsigned nxt;
            cap = longint'(1) << (31 - FRAC_BITS);
            case (phase)
                PH_IDLE:
                begin
                    clear_field();
                    if (b == start_code)
                    begin
                        phase = PH_ID;
                    end
                end
                PH_ID:
                begin
                    clear_field();
                    if (b != start_code)
                    begin
                        frame_id = b;
                        phase = PH_FIELD;
                    end
                end
                PH_FIELD:
                begin
                    if (b == CH_PLUS || b == CH_MINUS)
                    begin
                        if (sign_seen || char_count != 0 || char_count >= MAX_CHARS)
                        begin
                            phase = PH_IDLE;
                        end
                        else
                        begin
                            char_count++;
                            sign_seen = 1'b1;
                            negative = (b == CH_MINUS);
                        end
                    end
                    else if (b == CH_POINT)
                    begin
                        if (point_seen || char_count >= MAX_CHARS)
                        begin
                            phase = PH_IDLE;
                        end
                        else
                        begin
                            char_count++;
                            point_seen = 1'b1;
                        end
                    end
                    else if (b >= CH_ZERO && b <= CH_NINE)
                    begin
                        if (char_count >= MAX_CHARS)
                        begin
                            phase = PH_IDLE;
                        end
                        else
                        begin
                            char_count++;
                            if (point_seen)
                            begin
                                if (frac_digits < KEEP_DIGITS)
                                begin
                                    frac_mag = frac_mag * 10 + (b - CH_ZERO);
                                    frac_digits++;
                                end
                            end
                            else
                            begin
                                nxt = int_mag * 10 + (b - CH_ZERO);
                                if (nxt > cap)
                                begin
                                    nxt = cap;
                                    overflowed = 1'b1;
                                end
                                int_mag = nxt;
                            end
                        end
                    end
                    else if (b == start_code)
                    begin
                        clear_field();
                        phase = PH_ID;
                    end
                    else if (b == stop_code)
                    begin
                        awaited_frames.push_back(finish_frame());
                        phase = PH_IDLE;
                    end
                    else
                    begin
                        phase = PH_IDLE;
                    end
                end
                default:
                begin
                    phase = PH_IDLE;
                end
            endcase
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t ns: %s", $realtime, what);
            errors++;
        endtask

        task check_result(logic [7:0] id, logic [31:0] value, logic sat);
            frame_result_t e;
            if (awaited_frames.size() == 0)
            begin
                report_mismatch($sformatf("unexpected frame id=%02h value=%08h sat=%0b",
                                          id, value, sat));
            end
            else
            begin
                e = awaited_frames.pop_front();
                if (id !== e.command_id)
                begin
                    report_mismatch($sformatf("command_id %02h, predicted %02h",
                                              id, e.command_id));
                end
                if (value !== e.value)
                begin
                    report_mismatch($sformatf("value_q15_16 %08h, predicted %08h (id %02h)",
                                              value, e.value, e.command_id));
                end
                if (sat !== e.saturated)
                begin
                    report_mismatch($sformatf("saturated %0b, predicted %0b (id %02h)",
                                              sat, e.saturated, e.command_id));
                end
            end
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [7:0]           rx_byte;
    logic                 out_valid;
    logic                 out_ready;
    logic [7:0]           command_id;
    logic signed [31:0]   value_q15_16;
    logic                 saturated;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    frame_checker         frames;
    int                   idle_pct;
    int                   stall_pct;
    bit                   hold_req;
    int                   frame_beats;
    logic [7:0]           cur_start;
    logic [7:0]           cur_stop;

    ascii_command_frame_parser_unit #(
        .MAX_CHARS(MAX_CHARS_DEFAULT),
        .FRAC_BITS(FRAC_BITS_DEFAULT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .command_id(command_id),
        .value_q15_16(value_q15_16),
        .saturated(saturated),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // 10 ns clock.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Output side: out_ready changes on the falling edge. A hold-off request
    // from the stimulus keeps it low for HOLD_CYCLES, counted here, so that
    // the frame queue fills and in_ready drops while bytes keep coming.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ready = ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Every output beat is checked at the rising edge where it is taken.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            frames.check_result(command_id, value_q15_16, saturated);
        end
    end

    // Offer one input beat. Called at a falling edge; returns at the falling
    // edge after the beat was taken, with in_valid still high so that a
    // following call can present the next byte without a bubble.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        rx_byte  = b;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        frames.take_byte(b);
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i]);
        end
    endtask

    // Stop offering bytes and wait until every predicted frame has come out,
    // then give the converter time to finish anything that yields no beat.
    task automatic wait_drained();
        in_valid = 1'b0;
        while (frames.awaited_frames.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_SLACK) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        frames.set_register(idx, data);
        if (idx == CFG_START_IDX)
        begin
            cur_start = data;
        end
        else
        begin
            cur_stop = data;
        end
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_delimiters(input logic [7:0] s, input logic [7:0] p);
        wait_drained();
        write_register(CFG_START_IDX, s);
        write_register(CFG_STOP_IDX, p);
    endtask

    function automatic logic [7:0] random_digit();
        return 8'(CH_ZERO + $urandom_range(0, 9));
    endfunction

    // One frame with random content. Most are well formed; some get a byte
    // replaced or a stray sign or point inserted so that the abort paths run.
    task automatic send_random_frame();
        logic [7:0] beats[$];
        int         ilen;
        int         flen;
        int         pos;
        beats.push_back(cur_start);
        beats.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 99) < 40)
        begin
            beats.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
        end
        ilen = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 5) : $urandom_range(0, 17);
        for (int i = 0; i < ilen; i++)
        begin
            beats.push_back(random_digit());
        end
        if ($urandom_range(0, 1))
        begin
            beats.push_back(CH_POINT);
            flen = $urandom_range(0, 7);
            for (int i = 0; i < flen; i++)
            begin
                beats.push_back(random_digit());
            end
        end
        beats.push_back(cur_stop);
        if ($urandom_range(0, 99) < 15)
        begin
            pos = $urandom_range(2, beats.size() - 1);
            case ($urandom_range(0, 2))
                0: beats[pos] = 8'($urandom_range(0, 255));
                1: beats.insert(pos, CH_POINT);
                default: beats.insert(pos, CH_MINUS);
            endcase
        end
        foreach (beats[i])
        begin
            send_byte(beats[i]);
        end
        frame_beats += beats.size();
    endtask

    task automatic run_random(input int beats_wanted);
        int noise;
        frame_beats = 0;
        while (frame_beats < beats_wanted)
        begin
            if ($urandom_range(0, 99) < 12)
            begin
                noise = $urandom_range(1, 4);
                repeat (noise) send_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                send_random_frame();
            end
        end
    endtask

    // Directed frames with the default delimiters: signs, points, the
    // integer limit on both sides, truncated fractions, field length at and
    // past the maximum, restarts, aborts, the stop byte as an id and empty
    // fields.
    string directed_frames[] = '{
        "$a+1.5#", "$b-32768#", "$c32768#", "$d-32768.5#", "$e99999#",
        "$f.123456789#", "$g32767.99999#", "$h1-#", "$i1..2#", "$j++1#",
        "$k1234567890123456#", "$l12345678901234567#", "$$m5#", "$n12$o7#",
        "$pX#", "$##-0.5#", "$q.#", "$r+.#", "$s0.00001#", "$t-0.000005#", "$u#"
    };

    // Random delimiters kept clear of the field characters and of each other.
    task automatic random_delimiters();
        logic [7:0] s;
        logic [7:0] p;
        do
        begin
            s = 8'($urandom_range(0, 255));
        end while (s >= CH_PLUS && s <= CH_NINE);
        do
        begin
            p = 8'($urandom_range(0, 255));
        end while ((p >= CH_PLUS && p <= CH_NINE) || p == s);
        set_delimiters(s, p);
    endtask

    initial
    begin
        in_valid  = 1'b0;
        rx_byte   = 8'h00;
        cfg_valid = 1'b0;
        cfg_index = CFG_START_IDX;
        cfg_data  = 8'h00;
        idle_pct  = 0;
        stall_pct = 0;
        hold_req  = 1'b0;
        cur_start = START_RESET;
        cur_stop  = STOP_RESET;
        frames    = new();
        rst_n     = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, no idling on either side.
        set_delimiters(START_RESET, STOP_RESET);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(START_RESET);
        send_byte(8'hFF);
        send_text("-#");
        send_byte(START_RESET);
        send_byte(8'h00);
        send_text("#");
        foreach (directed_frames[i])
        begin
            send_text(directed_frames[i]);
        end

        // Delimiters that collide with field characters: the field meaning
        // wins, so these frames cannot close.
        set_delimiters(CH_ZERO, CH_PLUS);
        send_text("0A+0+05+");
        // Equal delimiters: the start meaning wins and no frame closes.
        set_delimiters(8'h40, 8'h40);
        send_text("@A1@B2@");

        // Fill the frame queue: output held off while short frames stream in.
        set_delimiters(START_RESET, STOP_RESET);
        hold_req = 1'b1;
        repeat (HOLD_FRAMES)
        begin
            send_byte(cur_start);
            send_byte(8'($urandom_range(0, 255)));
            send_byte(random_digit());
            send_byte(cur_stop);
        end
        // The sender pauses until all of those frames are out.
        wait_drained();
        run_random(PHASE_BEATS / 2);

        // Idling phases, each with its own delimiter setting.
        set_delimiters(8'h00, 8'hFF);
        idle_pct = 57;
        stall_pct = 0;
        run_random(PHASE_BEATS);

        set_delimiters(8'hFF, 8'h00);
        idle_pct = 0;
        stall_pct = 57;
        run_random(PHASE_BEATS);

        random_delimiters();
        idle_pct = 35;
        stall_pct = 35;
        run_random(PHASE_BEATS);

        set_delimiters(START_RESET, STOP_RESET);
        idle_pct = 35;
        stall_pct = 35;
        run_random(PHASE_BEATS);

        wait_drained();
        if (frames.errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog far above the slowest correct run.
    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/acfp_pkg.sv
sv/acfp_front.sv
sv/acfp_queue.sv
sv/acfp_back.sv
sv/ascii_command_frame_parser_unit.sv
tb/tb_top.sv
